// ===== hw/rtl/uidst_pkg.sv =====
package uidst_pkg;

    // Store geometry
    localparam int CAPACITY = 64;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Operation codes carried in the mode field
    localparam logic [2:0] MODE_INSERT = 3'd0;
    localparam logic [2:0] MODE_REMOVE = 3'd1;
    localparam logic [2:0] MODE_QUERY  = 3'd2;
    localparam logic [2:0] MODE_READ   = 3'd3;
    localparam logic [2:0] MODE_FILTER = 3'd4;

    // Status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [63:0] id_value;
        logic [5:0]         entry_index;
        logic signed [63:0] range_low;
        logic signed [63:0] range_high;
    } t_req;

    typedef struct packed {
        logic               present;
        logic signed [63:0] read_data;
        logic [6:0]         entry_count;
        logic               status;
        logic               filter_changed;
    } t_rsp;

    // Controller -> datapath
    typedef struct packed {
        logic load;
        logic walk;
        logic finish;
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic walk_busy;
        logic out_free;
    } t_sts;

endpackage

// ===== hw/rtl/uidst_if.sv =====
interface uidst_req_if;
    import uidst_pkg::*;

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface uidst_rsp_if;
    import uidst_pkg::*;

    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/unique_id_set_table_top.sv =====
// Channel | Dir | Modport              | Payload
// i_req   | in  | uidst_req_if.sink    | mode, id_value, entry_index, range_low, range_high
// o_rsp   | out | uidst_rsp_if.source  | present, read_data, entry_count, status,
//         |     |                      | filter_changed
//
// Walk: insert, remove, query and filter read the n valid entries one a cycle
//   through the single registered read port of the store; a read inside the
//   count reads one entry, and a read past the count or an unused mode reads
//   none. A new request is taken only after the last one has finished.
// Reset: i_rst_n synchronous, active low; empties the set (count 0). The store
//   itself is not cleared, entries past the count are never read.
// Stalls: the result sits in an output register; the next request is taken
//   while it waits, and that request holds in its finish step until the
//   register frees up.
module unique_id_set_table_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    uidst_req_if.sink          i_req,
    uidst_rsp_if.source        o_rsp
);
    import uidst_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Controller: idle -> walk over the store -> finish (write result).
    uidst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Datapath: entry store, search/compaction walk, count, response register.
    // Remove and filter compact in place: each kept entry is written back at
    // the kept index, which never passes the read pointer.
    uidst_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_req_data  (i_req.data),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_data  (o_rsp.data)
    );

endmodule

// ===== hw/rtl/uidst_ctrl.sv =====
module uidst_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  uidst_pkg::t_sts i_sts,
    output uidst_pkg::t_cmd o_cmd
);
    import uidst_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_WALK;
                end
            end
            ST_WALK: begin
                o_cmd.walk = 1'b1;
                if (!i_sts.walk_busy) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // hold until the response register can take the result
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // one command at a time, and never a finish while the walk still runs
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("controller issued more than one command");

    a_finish_after_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> !i_sts.walk_busy)
        else $error("finish while walk busy");

    a_load_then_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.walk)
        else $error("walk did not follow load");

endmodule

// ===== hw/rtl/uidst_dp.sv =====
module uidst_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  uidst_pkg::t_cmd i_cmd,
    output uidst_pkg::t_sts o_sts,
    input  uidst_pkg::t_req i_req_data,
    output logic            o_rsp_valid,
    input  logic            i_rsp_ready,
    output uidst_pkg::t_rsp o_rsp_data
);
    import uidst_pkg::*;

    localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;

    // entry store
    logic [63:0] r_mem [CAPACITY];
    logic [63:0] r_mem_q;

    // request context
    logic [2:0]         r_mode;
    logic [63:0]        r_val;
    logic signed [63:0] r_lo;
    logic signed [63:0] r_hi;

    // walk state
    logic [CNT_W-1:0] r_ptr;
    logic [CNT_W-1:0] r_end;
    logic [CNT_W-1:0] r_kept;
    logic             r_pend;
    logic             r_found;
    logic [63:0]      r_rdata;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    t_rsp r_rsp;
    logic r_rsp_vld;
    t_rsp n_rsp;

    // load-time decode
    logic             ld_walk;
    logic             ld_read_ok;
    logic [CNT_W-1:0] n_end;
    logic [CNT_W-1:0] n_ptr;

    // walk datapath
    logic              rd_en;
    logic              match;
    logic              in_range;
    logic              keep;
    logic              compact;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [63:0]       wdata;
    logic              full;

    assign full = (r_count == CNT_W'(CAPACITY));

    always_comb begin
        ld_walk = (i_req_data.mode == MODE_INSERT) || (i_req_data.mode == MODE_REMOVE) ||
                  (i_req_data.mode == MODE_QUERY)  || (i_req_data.mode == MODE_FILTER);
        ld_read_ok = (i_req_data.mode == MODE_READ) &&
                     (CMP_W'(i_req_data.entry_index) < CMP_W'(r_count));
        if (ld_walk) begin
            n_ptr = '0;
            n_end = r_count;
        end else if (ld_read_ok) begin
            n_ptr = CNT_W'(i_req_data.entry_index);
            n_end = CNT_W'(i_req_data.entry_index) + CNT_W'(1);
        end else begin
            n_ptr = '0;
            n_end = '0;
        end
    end

    assign rd_en    = i_cmd.walk && (r_ptr < r_end);
    assign match    = (r_mem_q == r_val);
    assign in_range = ($signed(r_mem_q) >= r_lo) && ($signed(r_mem_q) <= r_hi);
    assign compact  = (r_mode == MODE_REMOVE) || (r_mode == MODE_FILTER);
    assign keep     = (r_mode == MODE_REMOVE) ? !match : in_range;

    // finish: result and end-of-operation updates
    always_comb begin
        n_count = r_count;
        n_rsp   = '0;
        case (r_mode)
            MODE_INSERT: begin
                n_rsp.present = r_found;
                if (!r_found) begin
                    if (full) begin
                        n_rsp.status = STATUS_FULL;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
            end
            MODE_REMOVE: begin
                n_rsp.present = r_found;
                n_count       = r_kept;
            end
            MODE_QUERY: begin
                n_rsp.present = r_found;
            end
            MODE_READ: begin
                n_rsp.read_data = r_rdata;
            end
            MODE_FILTER: begin
                n_rsp.filter_changed = (r_kept != r_count);
                n_count              = r_kept;
            end
            default: begin
                n_count = r_count;
            end
        endcase
        n_rsp.entry_count = 7'(n_count);
    end

    // single write port: compaction during the walk, append at finish
    always_comb begin
        we    = 1'b0;
        waddr = r_kept[ADDR_W-1:0];
        wdata = r_mem_q;
        if (r_pend && compact && keep) begin
            we = 1'b1;
        end else if (i_cmd.finish && (r_mode == MODE_INSERT) && !r_found && !full) begin
            we    = 1'b1;
            waddr = r_count[ADDR_W-1:0];
            wdata = r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_mem_q <= r_mem[r_ptr[ADDR_W-1:0]];
        end
    end

    // request context, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_req_data.mode;
            r_val  <= i_req_data.id_value;
            if ($signed(i_req_data.range_low) > $signed(i_req_data.range_high)) begin
                r_lo <= i_req_data.range_high;
                r_hi <= i_req_data.range_low;
            end else begin
                r_lo <= i_req_data.range_low;
                r_hi <= i_req_data.range_high;
            end
            r_end <= n_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_pend    <= 1'b0;
            r_ptr     <= '0;
            r_kept    <= '0;
            r_found   <= 1'b0;
            r_rsp_vld <= 1'b0;
        end else begin
            r_pend <= rd_en;
            if (i_cmd.load) begin
                r_ptr   <= n_ptr;
                r_kept  <= '0;
                r_found <= 1'b0;
                r_rdata <= '1;
            end else begin
                if (rd_en) begin
                    r_ptr <= r_ptr + CNT_W'(1);
                end
                if (r_pend) begin
                    if (match) begin
                        r_found <= 1'b1;
                    end
                    if (compact && keep) begin
                        r_kept <= r_kept + CNT_W'(1);
                    end
                    r_rdata <= r_mem_q;
                end
            end
            if (i_cmd.finish) begin
                r_count   <= n_count;
                r_rsp     <= n_rsp;
                r_rsp_vld <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_vld <= 1'b0;
            end
        end
    end

    assign o_sts.walk_busy = (r_ptr < r_end) || r_pend;
    assign o_sts.out_free  = !r_rsp_vld || i_rsp_ready;
    assign o_rsp_valid     = r_rsp_vld;
    assign o_rsp_data      = r_rsp;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_write_behind_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kept <= r_ptr)
        else $error("compaction write overtook the read pointer");

    a_finish_walk_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> (!r_pend && (r_ptr == r_end)))
        else $error("finish with reads outstanding");

    a_no_rsp_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> (!r_rsp_vld || i_rsp_ready))
        else $error("response register overwritten");

    a_pend_from_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> $past(i_cmd.walk))
        else $error("read data pending without a walk");

endmodule
